### hdl/assert_macros.svh
// Assertion macros shared by the lease table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SLT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lease table check failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define SLT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lease table check failed: next-cycle implication");

`endif

### hdl/slt_pkg.sv
// Constants, codes and types of the lease table.
package slt_pkg;

	localparam int NUM_ENTRIES = 1024;
	localparam int MAX_OWNERS  = 8;
	localparam int ID_BITS     = 16;

	localparam int ENT_W    = 10;                     // entry_index field width
	localparam int REQID_W  = 16;                     // requester_id field width
	localparam int CNT_W    = 4;                      // owner count width
	localparam int SLOT_W   = $clog2(MAX_OWNERS);     // slot index within an entry
	localparam int OWN_DW   = ID_BITS + 1;            // owner slot: id and write bit
	localparam int OWN_AW   = ENT_W + SLOT_W;
	localparam int OWN_DEPTH = NUM_ENTRIES * MAX_OWNERS;
	localparam int ENT_DW   = 2 + CNT_W;              // mode and count per entry

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] MODE_UNOWNED    = 2'd0;
	localparam logic [1:0] MODE_READ       = 2'd1;
	localparam logic [1:0] MODE_WRITE      = 2'd2;
	localparam logic [1:0] MODE_READ_WRITE = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_SHARED  = 2'd1;
	localparam logic [1:0] STAT_BUSY    = 2'd2;
	localparam logic [1:0] STAT_INVALID = 2'd3;

	localparam logic [1:0] NTF_NONE    = 2'd0;
	localparam logic [1:0] NTF_SHARE   = 2'd1;
	localparam logic [1:0] NTF_PRIVATE = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_SEARCH,
		ST_COMPACT,
		ST_UPDATE,
		ST_DONE
	} slt_state_t;

endpackage

### hdl/slt_req_if.sv
// Request channel of the lease table.
interface slt_req_if;
	import slt_pkg::*;

	logic               valid;
	logic               ready;
	logic               opcode;
	logic [ENT_W-1:0]   entry_index;
	logic [REQID_W-1:0] requester_id;
	logic               want_write;

	modport source (output valid, opcode, entry_index, requester_id, want_write,
		input ready);
	modport sink (input valid, opcode, entry_index, requester_id, want_write,
		output ready);
endinterface

### hdl/slt_rsp_if.sv
// Result channel of the lease table.
interface slt_rsp_if;
	import slt_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [1:0]       notify;
	logic [1:0]       mode_after;
	logic [CNT_W-1:0] owners_after;

	modport source (output valid, status, notify, mode_after, owners_after,
		input ready);
	modport sink (input valid, status, notify, mode_after, owners_after,
		output ready);
endinterface

### hdl/shared_lease_table.sv
// Lease table top level: entry store, owner store and the request sequencer.
//
// Each of the 1024 entries keeps a mode and an ordered list of up to eight
// owners (requester id and write bit). An acquire appends the requester and
// moves the mode; a release removes the first owner with a matching id and
// closes the gap. Each accepted request gives exactly one result. After
// reset the block sweeps the entry store to unowned, one entry a cycle, so
// req.ready stays low until every entry is cleared. Then one request is worked
// at a time through a two-port owner store (one read and one write a
// cycle): an acquire, a full list or a bad index goes from the lookup step
// straight to the done step; a release searches the owner slots in order,
// moves the later slots up when the id is found, then updates the entry.
// A finished result sits in an output register, so the next request is
// taken while rsp waits; the sequencer only holds in its last step if the
// previous result has still not been taken.
`include "assert_macros.svh"

module shared_lease_table (
	input  logic      clk,
	input  logic      arst_n,
	slt_req_if.sink   req,
	slt_rsp_if.source rsp
);
	import slt_pkg::*;

	// Stores
	logic [ENT_DW-1:0] ent_mem [NUM_ENTRIES];
	logic [OWN_DW-1:0] own_mem [OWN_DEPTH];

	// Sequencer and request registers
	slt_state_t         state_q, state_d;
	logic [ENT_W-1:0]   clr_q;
	logic               op_q;
	logic [ENT_W-1:0]   idx_q;
	logic [ID_BITS-1:0] id_q;
	logic               wr_q;
	logic [ENT_DW-1:0]  ent_rd_q;
	logic [OWN_DW-1:0]  own_rd_q;
	logic [SLOT_W-1:0]  ptr_q, ptr_d;
	logic               keep_wr_q, keep_wr_d;

	// Result being built, and the output register
	logic [1:0]       res_status_q, res_status_d;
	logic [1:0]       res_notify_q, res_notify_d;
	logic [1:0]       res_mode_q, res_mode_d;
	logic [CNT_W-1:0] res_cnt_q, res_cnt_d;
	logic             ovalid_q;
	logic [1:0]       out_status_q, out_notify_q, out_mode_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic             out_load;

	// Store ports
	logic              ent_we;
	logic [ENT_W-1:0]  ent_wa;
	logic [ENT_DW-1:0] ent_wd;
	logic              own_we;
	logic [OWN_AW-1:0] own_wa;
	logic [OWN_DW-1:0] own_wd;
	logic [OWN_AW-1:0] own_ra;

	// Decoded entry and helpers
	logic             req_fire;
	logic [1:0]       cur_mode;
	logic [CNT_W-1:0] cur_cnt;
	logic [CNT_W-1:0] acq_base;
	logic [CNT_W-1:0] rel_cnt;
	logic [CNT_W-1:0] ptr_plus1;
	logic [CNT_W-1:0] ptr_plus2;
	logic             id_hit;
	logic             idx_bad;

	assign req_fire  = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);

	assign cur_mode  = ent_rd_q[ENT_DW-1 -: 2];
	assign cur_cnt   = ent_rd_q[CNT_W-1:0];
	assign acq_base  = (cur_mode == MODE_UNOWNED) ? '0 : cur_cnt;
	assign rel_cnt   = cur_cnt - CNT_W'(1);
	assign ptr_plus1 = CNT_W'(ptr_q) + CNT_W'(1);
	assign ptr_plus2 = CNT_W'(ptr_q) + CNT_W'(2);
	assign id_hit    = (own_rd_q[OWN_DW-1:1] == id_q);
	assign idx_bad   = ({1'b0, idx_q} >= (ENT_W+1)'(NUM_ENTRIES));

	assign rsp.valid        = ovalid_q;
	assign rsp.status       = out_status_q;
	assign rsp.notify       = out_notify_q;
	assign rsp.mode_after   = out_mode_q;
	assign rsp.owners_after = out_cnt_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ENT_W'(1);
			end
		end
	end

	// Next state, store control and result build-up
	always_comb begin
		state_d      = state_q;
		ptr_d        = ptr_q;
		keep_wr_d    = keep_wr_q;
		res_status_d = res_status_q;
		res_notify_d = res_notify_q;
		res_mode_d   = res_mode_q;
		res_cnt_d    = res_cnt_q;
		ent_we       = 1'b0;
		ent_wa       = idx_q;
		ent_wd       = '0;
		own_we       = 1'b0;
		own_wa       = {idx_q, ptr_q};
		own_wd       = own_rd_q;
		own_ra       = {idx_q, ptr_q + SLOT_W'(1)};
		out_load     = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				// Sweep every entry to unowned with no owners.
				ent_we = 1'b1;
				ent_wa = clr_q;
				ent_wd = '0;
				if (clr_q == ENT_W'(NUM_ENTRIES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_fire) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				// Entry word is in ent_rd_q; prefetch the first owner slot.
				own_ra       = {idx_q, SLOT_W'(0)};
				ptr_d        = '0;
				res_notify_d = NTF_NONE;
				if (idx_bad) begin
					res_status_d = STAT_INVALID;
					res_mode_d   = MODE_UNOWNED;
					res_cnt_d    = '0;
					state_d      = ST_DONE;
				end else if (op_q == OP_ACQUIRE) begin
					res_mode_d   = cur_mode;
					res_cnt_d    = cur_cnt;
					state_d      = ST_DONE;
					if (cur_mode != MODE_UNOWNED && cur_cnt >= CNT_W'(MAX_OWNERS)) begin
						// Owner list full: report busy, leave the entry alone.
						res_status_d = STAT_BUSY;
					end else begin
						res_status_d = STAT_OK;
						if (cur_mode == MODE_UNOWNED) begin
							res_mode_d = wr_q ? MODE_WRITE : MODE_READ;
						end else if (wr_q) begin
							res_mode_d   = MODE_READ_WRITE;
							res_status_d = STAT_SHARED;
							if (cur_mode != MODE_READ_WRITE) begin
								res_notify_d = NTF_SHARE;
							end
						end else if (cur_mode == MODE_WRITE) begin
							res_mode_d   = MODE_READ_WRITE;
							res_status_d = STAT_SHARED;
							res_notify_d = NTF_SHARE;
						end else if (cur_mode == MODE_READ_WRITE) begin
							res_status_d = STAT_SHARED;
						end
						res_cnt_d = acq_base + CNT_W'(1);
						// Append the owner and store the new entry word.
						own_we = 1'b1;
						own_wa = {idx_q, acq_base[SLOT_W-1:0]};
						own_wd = {id_q, wr_q};
						ent_we = 1'b1;
						ent_wd = {res_mode_d, res_cnt_d};
					end
				end else begin
					res_mode_d = cur_mode;
					res_cnt_d  = cur_cnt;
					if (cur_mode == MODE_UNOWNED || cur_cnt == '0) begin
						res_status_d = STAT_INVALID;
						state_d      = ST_DONE;
					end else begin
						state_d = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				// own_rd_q holds slot ptr_q; the next slot is being fetched.
				if (id_hit) begin
					if (ptr_plus1 == cur_cnt) begin
						state_d = ST_UPDATE;
					end else begin
						state_d = ST_COMPACT;
					end
				end else begin
					if (ptr_q == '0) begin
						keep_wr_d = own_rd_q[0];
					end
					if (ptr_plus1 == cur_cnt) begin
						// Requester not in the list: report the entry unchanged.
						res_status_d = STAT_INVALID;
						state_d      = ST_DONE;
					end else begin
						ptr_d = ptr_q + SLOT_W'(1);
					end
				end
			end
			ST_COMPACT: begin
				// Move slot ptr_q+1 down into ptr_q, fetch the one after.
				own_we = 1'b1;
				own_wa = {idx_q, ptr_q};
				own_wd = own_rd_q;
				own_ra = {idx_q, ptr_q + SLOT_W'(2)};
				if (ptr_q == '0) begin
					keep_wr_d = own_rd_q[0];
				end
				ptr_d = ptr_q + SLOT_W'(1);
				if (ptr_plus2 == cur_cnt) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				res_status_d = STAT_OK;
				res_notify_d = NTF_NONE;
				res_cnt_d    = rel_cnt;
				res_mode_d   = cur_mode;
				if (rel_cnt == '0) begin
					res_mode_d = MODE_UNOWNED;
				end else if (rel_cnt == CNT_W'(1) && cur_mode == MODE_READ_WRITE) begin
					// Last remaining owner goes back to a private lease.
					res_mode_d   = keep_wr_q ? MODE_WRITE : MODE_READ;
					res_notify_d = NTF_PRIVATE;
				end
				ent_we  = 1'b1;
				ent_wd  = {res_mode_d, res_cnt_d};
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// Hand the result over once the output register is free.
				if (!ovalid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Request capture and sequencer data registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q     <= req.opcode;
			idx_q    <= req.entry_index;
			id_q     <= req.requester_id[ID_BITS-1:0];
			wr_q     <= req.want_write;
			ent_rd_q <= ent_mem[req.entry_index];
		end
		ptr_q        <= ptr_d;
		keep_wr_q    <= keep_wr_d;
		res_status_q <= res_status_d;
		res_notify_q <= res_notify_d;
		res_mode_q   <= res_mode_d;
		res_cnt_q    <= res_cnt_d;
	end

	// Entry store write port
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_wa] <= ent_wd;
		end
	end

	// Owner store: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (own_we) begin
			own_mem[own_wa] <= own_wd;
		end
		own_rd_q <= own_mem[own_ra];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_notify_q <= res_notify_q;
			out_mode_q   <= res_mode_q;
			out_cnt_q    <= res_cnt_q;
		end
	end

	// Checks
	`SLT_ASSERT_NXT(a_busy_after_accept, req_fire, !req.ready)
	`SLT_ASSERT_IMP(a_busy_means_full, rsp.valid && rsp.status == STAT_BUSY, rsp.owners_after == CNT_W'(MAX_OWNERS))
	`SLT_ASSERT_IMP(a_unowned_empty, rsp.valid && rsp.mode_after == MODE_UNOWNED, rsp.owners_after == '0)
	`SLT_ASSERT_IMP(a_private_one_owner, rsp.valid && rsp.notify == NTF_PRIVATE, rsp.owners_after == CNT_W'(1))

endmodule
